### design/fall_weight_window_compensator_top_macros.svh
// Assertion helpers shared by the compensator modules.
`ifndef FALL_WEIGHT_WINDOW_COMPENSATOR_TOP_MACROS_SVH
`define FALL_WEIGHT_WINDOW_COMPENSATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define FWWC_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fwwc: same-cycle check failed");
// Next-cycle implication, disabled in reset.
`define FWWC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fwwc: next-cycle check failed");
`else
`define FWWC_ASSERT_IMPL(label, clk, rst, pre, post)
`define FWWC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### design/fwwc_pkg.sv
package fwwc_pkg;

  // Window and field widths
  localparam int WINDOW_DEPTH = 7;
  localparam int CNT_W        = 3;
  localparam int W_W          = 24;
  localparam int TIME_W       = 16;
  localparam int CLIP_W       = 23;
  localparam int GAIN_W       = 7;
  localparam int CFG_W        = 23;
  localparam int IDX_W        = 2;

  // Arithmetic widths
  localparam int SUM_W     = 26;
  localparam int BEST_W    = 26;
  localparam int TRIM_W    = 28;
  localparam int Y4_W      = 27;
  localparam int Y2_W      = 25;
  localparam int DIV_W     = 30;
  localparam int DIVISOR_W = 7;

  // Reciprocal division: x / 14 = ((x >> 1) * RCP7) >> RCP7_SH,
  // x / 100 = ((x >> 2) * RCP25) >> RCP25_SH, exact over the dividend ranges in use
  localparam int                 RCP_A_W   = 28;
  localparam int                 RCP_M_W   = 29;
  localparam int                 RCP_P_W   = RCP_A_W + RCP_M_W;
  localparam int                 RCP7_PRE  = 1;
  localparam int                 RCP25_PRE = 2;
  localparam logic [RCP_M_W-1:0] RCP7      = 29'd76695845;
  localparam logic [RCP_M_W-1:0] RCP25     = 29'd343597384;
  localparam int                 RCP7_SH   = 29;
  localparam int                 RCP25_SH  = 33;

  // Constants of the algorithm
  localparam int TIME_MARGIN  = 20;
  localparam int DIV_TRIM     = 14;
  localparam int DIV_PCT      = 100;
  localparam int MEAN_SAMPLES = 2;
  localparam int S24_MAX      = 8388607;
  localparam int S24_MIN      = -8388608;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TIME_MIN     = 2'd0;
  localparam logic [IDX_W-1:0] REG_CLIP_RANGE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_PERCENT = 2'd2;

  typedef struct packed {
    logic                    cmd;
    logic [TIME_W-1:0]       feed_time;
    logic signed [W_W-1:0]   stop_point;
    logic signed [W_W-1:0]   fall_weight;
  } in_t;

  typedef struct packed {
    logic signed [W_W-1:0]   new_stop_point;
    logic [CNT_W-1:0]        samples_held;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic do_clear;
    logic do_short;
    logic do_take;
    logic load_sort;
    logic sort_step;
    logic sort_odd;
    logic est;
    logic div_start;
    logic div_sel100;
    logic load14;
    logic mul;
    logic finish;
    logic emit;
  } fwwc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             is_clear;
    logic             is_short;
    logic [CNT_W-1:0] eff_cnt;
    logic             full;
    logic             div_busy;
    logic             out_busy;
  } fwwc_stat_t;

endpackage

### design/fwwc_div.sv
module fwwc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fwwc_pkg::DIV_W-1:0]     dividend,
  input  logic [fwwc_pkg::DIVISOR_W-1:0] divisor,
  output logic                           busy,
  output logic [fwwc_pkg::DIV_W-1:0]     quotient
);
  import fwwc_pkg::*;

  logic                 pct;
  logic [RCP_A_W-1:0]   opa;
  logic [RCP_P_W-1:0]   mprod;
  logic [DIV_W-1:0]     quo;

  // Multiply by the reciprocal of the odd factor
  assign mprod = RCP_P_W'(opa) * RCP_P_W'(pct ? RCP25 : RCP7);

  // Busy for the one multiply cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // Strip the power-of-two factor at start, then scale down the product
  always_ff @(posedge clk) begin
    if (start) begin
      pct <= (divisor == DIVISOR_W'(DIV_PCT));
      if (divisor == DIVISOR_W'(DIV_PCT)) begin
        opa <= RCP_A_W'(dividend >> RCP25_PRE);
      end else begin
        opa <= RCP_A_W'(dividend >> RCP7_PRE);
      end
    end else if (busy) begin
      quo <= pct ? DIV_W'(mprod >> RCP25_SH) : DIV_W'(mprod >> RCP7_SH);
    end
  end

  assign quotient = quo;

endmodule

### design/fwwc_ctrl.sv
`include "fall_weight_window_compensator_top_macros.svh"

module fwwc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fwwc_pkg::fwwc_stat_t stat,
  output fwwc_pkg::fwwc_cmd_t  cmd
);
  import fwwc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_SORT   = 4'd3;
  localparam logic [3:0] S_EST    = 4'd4;
  localparam logic [3:0] S_D14W   = 4'd5;
  localparam logic [3:0] S_CORR   = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DWAIT  = 4'd8;
  localparam logic [3:0] S_APPLY  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] sort_cnt;
  logic [CNT_W-1:0] sort_cnt_next;

  assign in_stall = (state != S_IDLE);

  // Sequence one request through the datapath
  always_comb begin
    cmd           = '0;
    state_next    = state;
    sort_cnt_next = sort_cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_clear) begin
          cmd.do_clear = 1'b1;
          state_next   = S_DONE;
        end else if (stat.is_short) begin
          cmd.do_short = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.do_take = 1'b1;
          if (stat.eff_cnt >= CNT_W'(MEAN_SAMPLES)) begin
            state_next = S_LOAD;
          end else if (stat.eff_cnt != '0) begin
            state_next = S_CORR;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_LOAD: begin
        cmd.load_sort = 1'b1;
        sort_cnt_next = '0;
        state_next    = S_SORT;
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = sort_cnt[0];
        sort_cnt_next = sort_cnt + CNT_W'(1);
        if (sort_cnt == CNT_W'(WINDOW_DEPTH - 1)) begin
          state_next = S_EST;
        end
      end
      S_EST: begin
        cmd.est = 1'b1;
        if (stat.full) begin
          cmd.div_start = 1'b1;
          state_next    = S_D14W;
        end else begin
          state_next = S_CORR;
        end
      end
      S_D14W: begin
        if (!stat.div_busy) begin
          cmd.load14 = 1'b1;
          state_next = S_CORR;
        end
      end
      S_CORR: begin
        cmd.mul    = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel100 = 1'b1;
        state_next     = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sort_cnt <= '0;
    end else begin
      state    <= state_next;
      sort_cnt <= sort_cnt_next;
    end
  end

  `FWWC_ASSERT_IMPL(a_div_only_in_wait, clk, rst, stat.div_busy, (state == S_D14W || state == S_DWAIT))
  `FWWC_ASSERT_NEXT(a_emit_frees_input, clk, rst, cmd.emit, !in_stall)
  `FWWC_ASSERT_IMPL(a_sort_bounded, clk, rst, state == S_SORT, sort_cnt < CNT_W'(WINDOW_DEPTH))

endmodule

### design/fwwc_dp.sv
`include "fall_weight_window_compensator_top_macros.svh"

module fwwc_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fwwc_pkg::IDX_W-1:0] cfg_index,
  input  logic [fwwc_pkg::CFG_W-1:0] cfg_data,
  input  fwwc_pkg::in_t              in_data,
  input  fwwc_pkg::fwwc_cmd_t        cmd,
  output fwwc_pkg::fwwc_stat_t       stat,
  input  logic                       out_stall,
  output logic                       out_valid,
  output fwwc_pkg::out_t             out_data
);
  import fwwc_pkg::*;

  // Configuration
  logic [TIME_W-1:0] time_min;
  logic [CLIP_W-1:0] clip_range;
  logic [GAIN_W-1:0] gain_percent;

  // Request and sample state
  in_t                   req;
  logic signed [W_W-1:0] window [WINDOW_DEPTH];
  logic [CNT_W-1:0]      count;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [W_W-1:0] last_result;
  logic                  full_mode;
  logic                  corr_en;
  logic                  neg14;

  // Sort lanes
  logic signed [W_W-1:0] srt      [WINDOW_DEPTH];
  logic signed [W_W-1:0] srt_next [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] sv;
  logic [WINDOW_DEPTH-1:0] sv_next;
  logic [WINDOW_DEPTH-2:0] swp;

  // Estimate and correction
  logic signed [BEST_W-1:0] best;
  logic [DIV_W-1:0]         prod;
  out_t                     res;

  logic [TIME_W:0]          thr;
  logic [CNT_W-1:0]         eff_cnt;
  logic signed [SUM_W-1:0]  sum2;
  logic signed [SUM_W-1:0]  sum2_adj;
  logic signed [BEST_W-1:0] mean2;
  logic signed [TRIM_W-1:0] sum14;
  logic signed [TRIM_W-1:0] abs14;
  logic signed [Y4_W-1:0]   y4;
  logic signed [Y4_W-1:0]   y4_adj;
  logic signed [Y2_W-1:0]   y2;
  logic signed [Y2_W-1:0]   y2_adj;
  logic signed [BEST_W-1:0] est_val;
  logic signed [BEST_W-1:0] last_ext;
  logic signed [BEST_W-1:0] diff;
  logic                     ge;
  logic [CLIP_W-1:0]        clipped;
  logic signed [BEST_W-1:0] delta;
  logic signed [BEST_W-1:0] q14;
  logic signed [BEST_W-1:0] corr_val;
  logic signed [BEST_W-1:0] fin_val;

  logic [DIV_W-1:0]         div_dividend;
  logic [DIVISOR_W-1:0]     div_divisor;
  logic                     div_busy;
  logic [DIV_W-1:0]         quotient;

  function automatic logic signed [W_W-1:0] sat_w(input logic signed [BEST_W-1:0] v);
    logic signed [W_W-1:0] r;
    if (v > BEST_W'(S24_MAX)) begin
      r = W_W'(S24_MAX);
    end else if (v < BEST_W'(S24_MIN)) begin
      r = W_W'(S24_MIN);
    end else begin
      r = W_W'(v);
    end
    return r;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_min     <= '0;
      clip_range   <= '0;
      gain_percent <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_MIN:     time_min     <= cfg_data[TIME_W-1:0];
        REG_CLIP_RANGE:   clip_range   <= cfg_data[CLIP_W-1:0];
        REG_GAIN_PERCENT: gain_percent <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  // Decode the request
  always_comb begin
    thr     = {1'b0, time_min} + (TIME_W + 1)'(TIME_MARGIN);
    eff_cnt = (last_result != req.stop_point) ? '0 : count;
    stat.is_clear = !req.cmd;
    stat.is_short = !(thr < {1'b0, req.feed_time});
    stat.eff_cnt  = eff_cnt;
    stat.full     = full_mode;
    stat.div_busy = div_busy;
    stat.out_busy = out_valid && out_stall;
  end

  // Running mean of the first two samples
  always_comb begin
    sum2     = ((eff_cnt == '0) ? '0 : running_sum) + SUM_W'(req.fall_weight);
    sum2_adj = sum2 + SUM_W'(sum2[SUM_W-1]);
    mean2    = BEST_W'(sum2_adj >>> 1);
  end

  // Sample count, window and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_sum <= '0;
    end else if (cmd.do_clear) begin
      count <= '0;
    end else if (cmd.do_take) begin
      if (eff_cnt == CNT_W'(WINDOW_DEPTH)) begin
        count <= CNT_W'(WINDOW_DEPTH);
      end else begin
        count <= eff_cnt + CNT_W'(1);
      end
      if (eff_cnt < CNT_W'(MEAN_SAMPLES)) begin
        running_sum <= sum2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_take) begin
      if (eff_cnt == CNT_W'(WINDOW_DEPTH)) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WINDOW_DEPTH-1] <= req.fall_weight;
      end else begin
        window[eff_cnt] <= req.fall_weight;
      end
    end
  end

  // Odd-even transposition pass; empty lanes sort to the top
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      swp[i] = (((i % 2) == 1) == cmd.sort_odd) &&
               ((sv[i+1] && !sv[i]) || (sv[i] && sv[i+1] && (srt[i] > srt[i+1])));
    end
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      srt_next[k] = srt[k];
    end
    sv_next = sv;
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      if (swp[i]) begin
        srt_next[i]   = srt[i+1];
        srt_next[i+1] = srt[i];
        sv_next[i]    = sv[i+1];
        sv_next[i+1]  = sv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sort) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        srt[i] <= window[i];
        sv[i]  <= (CNT_W'(i) < count);
      end
    end else if (cmd.sort_step) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        srt[i] <= srt_next[i];
      end
      sv <= sv_next;
    end
  end

  // Trimmed averages over the sorted window
  always_comb begin
    sum14 = TRIM_W'(srt[1]) + (TRIM_W'(srt[2]) <<< 2) +
            (TRIM_W'(srt[3]) <<< 2) + TRIM_W'(srt[3]) +
            (TRIM_W'(srt[4]) <<< 1) + TRIM_W'(srt[4]) + TRIM_W'(srt[5]);
    abs14  = sum14[TRIM_W-1] ? -sum14 : sum14;
    y4     = Y4_W'(srt[1]) + (Y4_W'(srt[2]) <<< 1) + Y4_W'(srt[3]);
    y4_adj = y4 + Y4_W'({2{y4[Y4_W-1]}});
    y2     = Y2_W'(srt[1]) + Y2_W'(srt[2]);
    y2_adj = y2 + Y2_W'(y2[Y2_W-1]);
    if (count >= CNT_W'(5)) begin
      est_val = BEST_W'(y4_adj >>> 2);
    end else if (count == CNT_W'(4)) begin
      est_val = BEST_W'(y2_adj >>> 1);
    end else begin
      est_val = BEST_W'(srt[1]);
    end
  end

  // Clip, gain and direction of the correction
  always_comb begin
    last_ext = BEST_W'(last_result);
    ge       = (last_ext >= best);
    diff     = ge ? (last_ext - best) : (best - last_ext);
    clipped  = ($unsigned(diff) > BEST_W'(clip_range)) ? clip_range : diff[CLIP_W-1:0];
    q14      = $signed(BEST_W'(quotient));
    delta    = $signed(BEST_W'(quotient));
    corr_val = ge ? (best - delta) : (best + delta);
    fin_val  = corr_en ? corr_val : best;
  end

  // Shared constant divider
  assign div_dividend = cmd.div_sel100 ? prod : DIV_W'($unsigned(abs14));
  assign div_divisor  = cmd.div_sel100 ? DIVISOR_W'(DIV_PCT) : DIVISOR_W'(DIV_TRIM);

  fwwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Estimate and mode flags
  always_ff @(posedge clk) begin
    if (cmd.do_take) begin
      full_mode <= (eff_cnt == CNT_W'(WINDOW_DEPTH));
      corr_en   <= (eff_cnt != '0);
      if (eff_cnt == '0) begin
        best <= BEST_W'(req.fall_weight);
      end else begin
        best <= mean2;
      end
    end else if (cmd.est) begin
      neg14 <= sum14[TRIM_W-1];
      if (!full_mode) begin
        best <= est_val;
      end
    end else if (cmd.load14) begin
      best <= neg14 ? -q14 : q14;
    end
    if (cmd.mul) begin
      prod <= DIV_W'(clipped) * DIV_W'(gain_percent);
    end
  end

  // Last result and staged result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_result <= '0;
    end else if (cmd.finish) begin
      last_result <= sat_w(fin_val);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_clear) begin
      res.new_stop_point <= '0;
      res.samples_held   <= '0;
    end else if (cmd.do_short) begin
      res.new_stop_point <= req.stop_point;
      res.samples_held   <= count;
    end else if (cmd.finish) begin
      res.new_stop_point <= sat_w(fin_val);
      res.samples_held   <= count;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= res;
    end
  end

  `FWWC_ASSERT_NEXT(a_take_counts, clk, rst, cmd.do_take, count != '0)
  `FWWC_ASSERT_IMPL(a_sort_lanes, clk, rst, cmd.est, $countones(sv) == int'(count))
  `FWWC_ASSERT_IMPL(a_sort_order, clk, rst, cmd.est && sv[1] && sv[2], srt[1] <= srt[2])

endmodule

### design/fall_weight_window_compensator_top.sv
// States to out_valid: a clear or short feed: IDLE, DECODE, DONE; a first sample adds APPLY;
// a second adds CORR, DSTART, DWAIT before APPLY; three to seven samples add LOAD, SORT, EST
// before CORR; a full window adds D14W after EST. The long paths are set by the seven-pass sort
// and the reciprocal-multiply divider. One request at a time, the next taken once the result
// is emitted; a stalled result holds the block only once the following result is ready.
// Reset (rst, synchronous, active high) clears the registers, sample count, sum, last result.
module fall_weight_window_compensator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [fwwc_pkg::IDX_W-1:0] cfg_index,
  input  logic [fwwc_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fwwc_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fwwc_pkg::out_t             out_data
);
  import fwwc_pkg::*;

  fwwc_cmd_t  cmd;
  fwwc_stat_t stat;

  // Sequencer
  fwwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Window, sort and arithmetic
  fwwc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
